>>> hw/rtl/huffman_code_builder_encoder_core_defines.svh
// assertion macros for the huffman code builder encoder core
// expects clk and rst_n in the scope of each use
`ifndef HUFFMAN_CODE_BUILDER_ENCODER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_ENCODER_CORE_DEFINES_SVH

// condition must hold at every edge out of reset
`define HCB_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hcb check failed");

// antecedent implies consequent on the next edge
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcb check failed");

`endif

>>> hw/rtl/hcb_pkg.sv
// shared types and constants of the huffman code builder encoder
// no dependencies
package hcb_pkg;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2
  } opcode_t;

  localparam int unsigned ALPHABET_DEF   = 26;
  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned CODE_W         = 25;
  localparam int unsigned LEN_W          = 5;
  localparam logic [7:0]  CHAR_A         = 8'h61;
  localparam logic [7:0]  CHAR_Z         = 8'h7a;

  // control for one work list cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic merge;
  } list_ctrl_t;

  // control for one letter cell
  typedef struct packed {
    logic init;
    logic merge;
  } letter_ctrl_t;

endpackage

>>> hw/rtl/huffman_code_builder_encoder_core.sv
// huffman code builder encoder: set and encode items are taken while the builder is idle
// build walks all ALPHABET letters inserting the present ones, then merges (present
// letters - 1) times and finishes; the list cell chain does one insert or merge per cycle
// encode result is registered at acceptance and waits in the output register
// synchronous active-low reset clears counts, presence flags, built flag and handshake state
module huffman_code_builder_encoder_core #(
  parameter int unsigned ALPHABET   = hcb_pkg::ALPHABET_DEF,
  parameter int unsigned COUNT_BITS = hcb_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [4:0]                 in_letter_index,
  input  logic [23:0]                in_frequency,
  input  logic [7:0]                 in_text_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hcb_pkg::CODE_W-1:0] out_code_bits,
  output logic [hcb_pkg::LEN_W-1:0]  out_code_length
);

`include "huffman_code_builder_encoder_core_defines.svh"

  // widths derived from the alphabet size
  localparam int unsigned LIW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned WW  = COUNT_BITS + LIW;       // merged weight
  localparam int unsigned NW  = $clog2(2 * ALPHABET - 1); // node id
  localparam int unsigned LW  = LIW;                    // code length, max ALPHABET-1

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_MERGE
  } state_t;

  state_t         state_r;
  logic [LIW-1:0] ins_idx_r;
  logic [NW-1:0]  next_id_r;
  logic           built_r;
  logic           out_valid_r;
  logic [hcb_pkg::CODE_W-1:0] out_code_r;
  logic [hcb_pkg::LEN_W-1:0]  out_len_r;

  // letter counts
  logic [COUNT_BITS-1:0] count_r [ALPHABET];

  // work list cells
  logic                list_v [ALPHABET];
  logic [WW-1:0]       list_w [ALPHABET];
  logic [NW-1:0]       list_n [ALPHABET];
  logic                list_keep [ALPHABET];
  logic [ALPHABET-1:0] list_vld;
  hcb_pkg::list_ctrl_t list_ctrl;
  logic [WW-1:0]       new_w;
  logic [NW-1:0]       new_n;

  // letter cells
  logic                       let_present [ALPHABET];
  logic [hcb_pkg::CODE_W-1:0] let_code [ALPHABET];
  logic [LW-1:0]              let_len [ALPHABET];
  hcb_pkg::letter_ctrl_t      let_ctrl;

  // input decode
  logic                  in_acc;
  logic                  is_set;
  logic                  is_build;
  logic                  is_encode;
  logic [7:0]            idx8;
  logic [31:0]           freq32;
  logic [7:0]            li8;
  logic                  enc_hit;
  logic                  enc_load;
  logic                  ins_cnt_nz;
  logic                  merge_go;
  logic [LW+hcb_pkg::LEN_W-1:0] len_ext;
  logic                  prefix_ok;

  assign is_set    = (in_opcode == hcb_pkg::OP_SET);
  assign is_build  = (in_opcode == hcb_pkg::OP_BUILD);
  assign is_encode = (in_opcode == hcb_pkg::OP_ENCODE);

  // encode needs a free output slot, others only need an idle builder
  assign in_stall = (state_r != ST_IDLE) || (is_encode && out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign idx8   = {3'b000, in_letter_index};
  assign freq32 = {8'h00, in_frequency};
  assign li8    = in_text_byte - hcb_pkg::CHAR_A;

  assign enc_hit = built_r
                && (in_text_byte >= hcb_pkg::CHAR_A) && (in_text_byte <= hcb_pkg::CHAR_Z)
                && (li8 < 8'(ALPHABET))
                && let_present[li8[LIW-1:0]];

  // an accepted encode of a coded letter fills the output register
  assign enc_load = (state_r == ST_IDLE) && in_acc && is_encode && enc_hit;

  assign len_ext = {{hcb_pkg::LEN_W{1'b0}}, let_len[li8[LIW-1:0]]};

  // insertion feeds one letter per cycle, skipping absent letters
  assign ins_cnt_nz = (count_r[ins_idx_r] != '0);
  // merge pops cells 0 and 1 while two or more entries remain
  assign merge_go   = (state_r == ST_MERGE) && list_v[1];

  always_comb begin
    list_ctrl.clear  = in_acc && is_build;
    list_ctrl.insert = (state_r == ST_INSERT) && ins_cnt_nz;
    list_ctrl.merge  = merge_go;
    let_ctrl.init    = in_acc && is_build;
    let_ctrl.merge   = merge_go;
    if (state_r == ST_MERGE) begin
      new_w = list_w[0] + list_w[1];
      new_n = next_id_r;
    end else begin
      new_w = WW'(count_r[ins_idx_r]);
      new_n = NW'(ins_idx_r);
    end
  end

  // count store, one write per set item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        count_r[i] <= '0;
      end
    end else if (in_acc && is_set && (idx8 < 8'(ALPHABET))) begin
      count_r[idx8[LIW-1:0]] <= freq32[COUNT_BITS-1:0];
    end
  end

  genvar g;
  generate
    for (g = 0; g < ALPHABET; g++) begin : g_cell
      logic          l_v, r1_v, r2_v, lk;
      logic [WW-1:0] l_w, r1_w, r2_w;
      logic [NW-1:0] l_n, r1_n, r2_n;

      if (g == 0) begin : g_first
        assign lk  = 1'b1;
        assign l_v = 1'b0;
        assign l_w = '0;
        assign l_n = '0;
      end else begin : g_mid
        assign lk  = list_keep[g-1];
        assign l_v = list_v[g-1];
        assign l_w = list_w[g-1];
        assign l_n = list_n[g-1];
      end

      if (g + 1 < ALPHABET) begin : g_r1
        assign r1_v = list_v[g+1];
        assign r1_w = list_w[g+1];
        assign r1_n = list_n[g+1];
      end else begin : g_r1_end
        assign r1_v = 1'b0;
        assign r1_w = '0;
        assign r1_n = '0;
      end

      if (g + 2 < ALPHABET) begin : g_r2
        assign r2_v = list_v[g+2];
        assign r2_w = list_w[g+2];
        assign r2_n = list_n[g+2];
      end else begin : g_r2_end
        assign r2_v = 1'b0;
        assign r2_w = '0;
        assign r2_n = '0;
      end

      hcb_list_cell #(
        .WW (WW),
        .NW (NW)
      ) u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (list_ctrl),
        .new_w     (new_w),
        .new_n     (new_n),
        .left_keep (lk),
        .l_v       (l_v),
        .l_w       (l_w),
        .l_n       (l_n),
        .r1_v      (r1_v),
        .r1_w      (r1_w),
        .r1_n      (r1_n),
        .r2_v      (r2_v),
        .r2_w      (r2_w),
        .r2_n      (r2_n),
        .keep      (list_keep[g]),
        .v_r       (list_v[g]),
        .w_r       (list_w[g]),
        .n_r       (list_n[g])
      );

      assign list_vld[g] = list_v[g];

      // cell 1 holds the left branch, cell 0 the right branch
      hcb_letter_cell #(
        .IDX (g),
        .NW  (NW),
        .LW  (LW)
      ) u_letter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (let_ctrl),
        .cnt_nz    (count_r[g] != '0),
        .lnode     (list_n[1]),
        .rnode     (list_n[0]),
        .new_id    (next_id_r),
        .present_r (let_present[g]),
        .code_r    (let_code[g]),
        .len_r     (let_len[g])
      );
    end
  endgenerate

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ins_idx_r   <= '0;
      next_id_r   <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result stays while stalled, a new one loads when the slot frees
      out_valid_r <= enc_load || (out_valid_r && out_stall);
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && is_build) begin
            state_r   <= ST_INSERT;
            ins_idx_r <= '0;
            next_id_r <= NW'(ALPHABET);
          end else if (enc_load) begin
            out_code_r  <= let_code[li8[LIW-1:0]];
            out_len_r   <= len_ext[hcb_pkg::LEN_W-1:0];
          end
        end
        ST_INSERT: begin
          if (ins_idx_r == LIW'(ALPHABET - 1)) begin
            state_r <= ST_MERGE;
          end else begin
            ins_idx_r <= ins_idx_r + LIW'(1);
          end
        end
        ST_MERGE: begin
          if (merge_go) begin
            next_id_r <= next_id_r + NW'(1);
          end else begin
            state_r <= ST_IDLE;
            built_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_bits   = out_code_r;
  assign out_code_length = out_len_r;

  // valid list cells always form a prefix starting at cell 0
  assign prefix_ok = (((list_vld + ALPHABET'(1)) & list_vld) == '0);

  `HCB_ASSERT_ALWAYS(a_list_prefix, prefix_ok)
  `HCB_ASSERT_NEXT(a_merge_shrinks, merge_go,
    $countones(list_vld) == $past($countones(list_vld)) - 1)
  `HCB_ASSERT_NEXT(a_encode_result, in_acc && is_encode && enc_hit, out_valid_r)

endmodule

>>> hw/rtl/hcb_list_cell.sv
// one cell of the sorted work list (smallest weight in cell 0)
// depends on hcb_pkg
module hcb_list_cell #(
  parameter int unsigned WW = 29,
  parameter int unsigned NW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hcb_pkg::list_ctrl_t ctrl,
  input  logic [WW-1:0]       new_w,
  input  logic [NW-1:0]       new_n,
  input  logic                left_keep,
  input  logic                l_v,
  input  logic [WW-1:0]       l_w,
  input  logic [NW-1:0]       l_n,
  input  logic                r1_v,
  input  logic [WW-1:0]       r1_w,
  input  logic [NW-1:0]       r1_n,
  input  logic                r2_v,
  input  logic [WW-1:0]       r2_w,
  input  logic [NW-1:0]       r2_n,
  output logic                keep,
  output logic                v_r,
  output logic [WW-1:0]       w_r,
  output logic [NW-1:0]       n_r
);

  logic          cand_v;
  logic [WW-1:0] cand_w;
  logic [NW-1:0] cand_n;
  logic          v_nxt;
  logic [WW-1:0] w_nxt;
  logic [NW-1:0] n_nxt;

  // on a merge the list is seen shifted down by two
  assign cand_v = ctrl.merge ? r2_v : v_r;
  assign cand_w = ctrl.merge ? r2_w : w_r;
  assign cand_n = ctrl.merge ? r2_n : n_r;
  assign keep   = cand_v && (cand_w < new_w);

  always_comb begin
    v_nxt = v_r;
    w_nxt = w_r;
    n_nxt = n_r;
    if (ctrl.clear) begin
      v_nxt = 1'b0;
    end else if (ctrl.insert || ctrl.merge) begin
      if (keep) begin
        v_nxt = cand_v;
        w_nxt = cand_w;
        n_nxt = cand_n;
      end else if (left_keep) begin
        v_nxt = 1'b1;
        w_nxt = new_w;
        n_nxt = new_n;
      end else if (ctrl.merge) begin
        v_nxt = r1_v;
        w_nxt = r1_w;
        n_nxt = r1_n;
      end else begin
        v_nxt = l_v;
        w_nxt = l_w;
        n_nxt = l_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    w_r <= w_nxt;
    n_r <= n_nxt;
  end

endmodule

>>> hw/rtl/hcb_letter_cell.sv
// one letter cell: subtree root, code word and length built up per merge
// depends on hcb_pkg
module hcb_letter_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned NW  = 6,
  parameter int unsigned LW  = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hcb_pkg::letter_ctrl_t       ctrl,
  input  logic                        cnt_nz,
  input  logic [NW-1:0]               lnode,
  input  logic [NW-1:0]               rnode,
  input  logic [NW-1:0]               new_id,
  output logic                        present_r,
  output logic [hcb_pkg::CODE_W-1:0]  code_r,
  output logic [LW-1:0]               len_r
);

  logic [NW-1:0]              root_r;
  logic [NW-1:0]              root_nxt;
  logic                       present_nxt;
  logic [hcb_pkg::CODE_W-1:0] code_nxt;
  logic [LW-1:0]              len_nxt;
  logic                       hit_l;
  logic                       hit_r;

  assign hit_l = present_r && (root_r == lnode);
  assign hit_r = present_r && (root_r == rnode);

  always_comb begin
    present_nxt = present_r;
    root_nxt    = root_r;
    code_nxt    = code_r;
    len_nxt     = len_r;
    if (ctrl.init) begin
      present_nxt = cnt_nz;
      root_nxt    = NW'(IDX);
      code_nxt    = '0;
      len_nxt     = '0;
    end else if (ctrl.merge && (hit_l || hit_r)) begin
      root_nxt = new_id;
      len_nxt  = len_r + LW'(1);
      // right branch prepends a one above the bits so far
      for (int b = 0; b < hcb_pkg::CODE_W; b++) begin
        if (hit_r && (int'(len_r) == b)) begin
          code_nxt[b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
    end else begin
      present_r <= present_nxt;
    end
    root_r <= root_nxt;
    code_r <= code_nxt;
    len_r  <= len_nxt;
  end

endmodule

>>> verif/huffman_code_builder_encoder_core_tb.sv
// testbench for the huffman code builder encoder core: directed and random items
// depends on hcb_pkg and huffman_code_builder_encoder_core; predicts codes in-bench
module huffman_code_builder_encoder_core_tb;

  localparam int NLET = 26;
  localparam int NNODE = 2 * NLET - 1;
  localparam int WATCHDOG_LIMIT = 20000;
  // opcode with no meaning, must be ignored
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_opcode;
  logic [4:0] in_letter_index;
  logic [23:0] in_frequency;
  logic [7:0] in_text_byte;
  logic out_valid;
  logic out_stall;
  logic [hcb_pkg::CODE_W-1:0] out_code_bits;
  logic [hcb_pkg::LEN_W-1:0] out_code_length;

  typedef struct packed {
    logic [hcb_pkg::CODE_W-1:0] bits;
    logic [hcb_pkg::LEN_W-1:0] len;
  } code_word_t;

  // predicted state of the block
  logic [23:0] pred_count [NLET];
  logic pred_present [NLET];
  code_word_t pred_code [NLET];
  logic pred_built;

  code_word_t pending_codes [$];
  int mismatch_count;
  int results_seen;
  int idle_cycles;
  bit timed_out;
  bit allow_out_stall;
  int encodes_sent;
  int builds_sent;

  huffman_code_builder_encoder_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_letter_index(in_letter_index),
    .in_frequency(in_frequency), .in_text_byte(in_text_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_bits(out_code_bits), .out_code_length(out_code_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rebuild the code table from the current counts
  task automatic build_table();
    logic [28:0] lw [NLET];
    int ln [NLET];
    int parent [NNODE];
    bit right [NNODE];
    int n, j, next_id, root, node, depth, tn;
    logic [28:0] tw;
    logic [63:0] code;
    n = 0;
    next_id = NLET;
    for (int i = 0; i < NLET; i++) begin
      pred_present[i] = (pred_count[i] != 0);
      pred_code[i] = '0;
      if (!pred_present[i]) continue;
      j = n;
      while (j > 0 && lw[j-1] < pred_count[i]) begin
        lw[j] = lw[j-1];
        ln[j] = ln[j-1];
        j--;
      end
      lw[j] = pred_count[i];
      ln[j] = i;
      n++;
    end
    pred_built = 1'b1;
    if (n == 0) return;
    while (n > 1) begin
      parent[ln[n-2]] = next_id;
      right[ln[n-2]] = 1'b0;
      parent[ln[n-1]] = next_id;
      right[ln[n-1]] = 1'b1;
      tw = lw[n-2] + lw[n-1];
      n--;
      j = n - 1;
      lw[j] = tw;
      ln[j] = next_id;
      next_id++;
      // merged node sinks only past strictly lighter entries
      while (j > 0 && lw[j] > lw[j-1]) begin
        tw = lw[j]; tn = ln[j];
        lw[j] = lw[j-1]; ln[j] = ln[j-1];
        lw[j-1] = tw; ln[j-1] = tn;
        j--;
      end
    end
    root = ln[0];
    for (int i = 0; i < NLET; i++) begin
      if (!pred_present[i]) continue;
      node = i;
      depth = 0;
      code = '0;
      // walk leaf to root, first bit from the root ends up at the msb
      while (node != root) begin
        if (right[node]) code[depth] = 1'b1;
        depth++;
        node = parent[node];
      end
      pred_code[i].bits = code[hcb_pkg::CODE_W-1:0];
      pred_code[i].len = depth[hcb_pkg::LEN_W-1:0];
    end
  endtask

  // apply one accepted item to the predictor
  task automatic predict_item(input logic [1:0] op, input logic [4:0] idx,
                              input logic [23:0] freq, input logic [7:0] ch);
    int li;
    unique case (op)
      hcb_pkg::OP_SET: begin
        if (idx < NLET) pred_count[idx] = freq;
      end
      hcb_pkg::OP_BUILD: begin
        build_table();
        builds_sent++;
      end
      hcb_pkg::OP_ENCODE: begin
        encodes_sent++;
        if (pred_built && ch >= hcb_pkg::CHAR_A && ch <= hcb_pkg::CHAR_Z) begin
          li = ch - hcb_pkg::CHAR_A;
          if (pred_present[li]) pending_codes.push_back(pred_code[li]);
        end
      end
      default: ;
    endcase
  endtask

  // sender gap: mostly none or short, now and then long
  task automatic sender_gap();
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send one item and wait for acceptance; valid stays up for a following item
  task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                           input logic [23:0] freq, input logic [7:0] ch,
                           input bit with_gap = 1'b1);
    if (with_gap) sender_gap();
    in_valid <= 1'b1;
    in_opcode <= op;
    in_letter_index <= idx;
    in_frequency <= freq;
    in_text_byte <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(op, idx, freq, ch);
  endtask

  task automatic set_count(input int idx, input logic [23:0] freq);
    send_item(hcb_pkg::OP_SET, idx[4:0], freq, 8'($urandom()));
  endtask

  task automatic build_now();
    send_item(hcb_pkg::OP_BUILD, 5'($urandom()), 24'($urandom()), 8'($urandom()));
  endtask

  task automatic encode_char(input logic [7:0] ch);
    send_item(hcb_pkg::OP_ENCODE, 5'($urandom()), 24'($urandom()), ch);
  endtask

  // input goes idle, then wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // result checker and random receiver stall
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_codes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: bits=%h len=%0d", out_code_bits, out_code_length);
        end else begin
          code_word_t exp_code;
          exp_code = pending_codes.pop_front();
          if (out_code_bits !== exp_code.bits || out_code_length !== exp_code.len) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("code mismatch: expected bits=%h len=%0d, got bits=%h len=%0d",
                       exp_code.bits, exp_code.len, out_code_bits, out_code_length);
          end
        end
      end
      r = $urandom_range(0, 99);
      if (!allow_out_stall) out_stall <= 1'b0;
      else if (out_stall) out_stall <= (r < 70);
      else out_stall <= (r < 20);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // encode before any build, unknown opcodes, sets outside the alphabet
  task automatic test_before_build();
    encode_char("a");
    encode_char("z");
    send_item(OP_RESERVED, 5'd31, 24'hffffff, 8'hff);
    set_count(26, 24'd5);
    set_count(31, 24'hffffff);
    build_now();
    encode_char("a");
  endtask

  // single letter, extreme counts, non-letters and absent letters
  task automatic test_directed();
    set_count(0, 24'd7);
    build_now();
    encode_char("a");
    encode_char("b");
    encode_char(8'h60);
    encode_char(8'h7b);
    encode_char(8'h00);
    encode_char(8'hff);
    set_count(25, 24'hffffff);
    set_count(1, 24'd1);
    set_count(2, 24'd1);
    encode_char("z");
    build_now();
    encode_char("a");
    encode_char("b");
    encode_char("c");
    encode_char("z");
    drain();
  endtask

  // fibonacci-like counts give the deepest tree
  task automatic test_deep_tree();
    int f0, f1, t;
    f0 = 1; f1 = 1;
    for (int i = 0; i < NLET; i++) begin
      set_count(i, f0[23:0]);
      t = f0 + f1; f0 = f1; f1 = t;
    end
    build_now();
    for (int i = 0; i < NLET; i++) encode_char(8'(hcb_pkg::CHAR_A + i));
    // equal counts for all letters
    for (int i = 0; i < NLET; i++) set_count(i, 24'd3);
    build_now();
    for (int i = 0; i < NLET; i++) encode_char(8'(hcb_pkg::CHAR_A + i));
    // clear all counts: empty table
    for (int i = 0; i < NLET; i++) set_count(i, 24'd0);
    build_now();
    encode_char("m");
    drain();
  endtask

  // sender holds off until the block has returned everything
  task automatic test_hold_off();
    for (int i = 0; i < 5; i++) set_count(i, 24'(i + 1));
    build_now();
    for (int i = 0; i < 8; i++) encode_char(8'(hcb_pkg::CHAR_A + $urandom_range(0, 6)));
    drain();
    repeat (5) @(posedge clk);
    encode_char("c");
  endtask

  // random rounds: mostly fresh count sets, a build, then many encodes
  task automatic test_random(input int n_items);
    int sent, r, k, letters;
    logic [23:0] f;
    sent = 0;
    while (sent < n_items) begin
      letters = ($urandom_range(0, 3) == 0) ? NLET : $urandom_range(1, 10);
      for (int i = 0; i < NLET; i++) begin
        r = $urandom_range(0, 99);
        if (i < letters || r < 10) begin
          r = $urandom_range(0, 9);
          f = (r == 0) ? 24'($urandom()) : (r == 1) ? 24'hffffff
              : 24'($urandom_range(0, 20));
          set_count(i, f);
          sent++;
        end
      end
      build_now();
      sent++;
      k = $urandom_range(10, 40);
      repeat (k) begin
        r = $urandom_range(0, 99);
        if (r < 75) encode_char(8'(hcb_pkg::CHAR_A + $urandom_range(0, NLET - 1)));
        else if (r < 85) encode_char(8'($urandom()));
        else if (r < 92) set_count($urandom_range(0, 31), 24'($urandom()));
        else send_item(OP_RESERVED, 5'($urandom()), 24'($urandom()), 8'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_letter_index = '0;
    in_frequency = '0;
    in_text_byte = '0;
    allow_out_stall = 1'b0;
    encodes_sent = 0;
    builds_sent = 0;
    for (int i = 0; i < NLET; i++) begin
      pred_count[i] = '0;
      pred_present[i] = 1'b0;
      pred_code[i] = '0;
    end
    pred_built = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_build();
    test_directed();
    allow_out_stall = 1'b1;
    test_deep_tree();
    test_hold_off();
    test_random(900);
    drain();
    allow_out_stall = 1'b0;
    repeat (20) @(posedge clk);
    $display("covered %0d builds and %0d encode items, %0d codes checked",
             builds_sent, encodes_sent, results_seen);
    if (mismatch_count == 0 && pending_codes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d codes never returned", mismatch_count,
               pending_codes.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
